>>> rtl/tdpt_pkg.sv
// Package for the trial-division prime test block.
// Holds the default operand width, the output bus width and the command and
// status structs that join the controller and the datapath.
package tdpt_pkg;

  // Default candidate width in bits.
  localparam int WIDTH_DEF = 8;

  // The result channel carries one flag, padded to a whole byte.
  localparam int OUT_DATA_W = 8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // Capture a new candidate and restart the divisor at two.
    logic start_div;  // Clear the remainder and point at the candidate's top bit.
    logic div_step;   // Retire one bit of the remainder calculation.
    logic next_div;   // Advance to the next divisor and its square.
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic lt_two;     // Candidate is zero or one.
    logic sq_gt_n;    // Square of the current divisor exceeds the candidate.
    logic rem_zero;   // Remainder of the last division is zero.
    logic div_last;   // The current division step handles the lowest bit.
  } dp_status_t;

endpackage

>>> rtl/tdpt_dpath.sv
// Datapath of the trial-division prime test: candidate, divisor and square
// registers and a bit-serial restoring remainder unit.
// Depends on tdpt_pkg for the command and status structs.
module tdpt_dpath #(
  parameter int WIDTH = tdpt_pkg::WIDTH_DEF
) (
  input  logic                   clk,
  input  logic [WIDTH-1:0]       candidate,
  input  tdpt_pkg::ctrl_cmd_t    cmd,
  output tdpt_pkg::dp_status_t   status
);

  localparam int SqW  = 2 * WIDTH;
  localparam int BitW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic [WIDTH-1:0] n_r;
  logic [WIDTH-1:0] d_r;
  logic [SqW-1:0]   sq_r;
  logic [WIDTH-1:0] rem_r;
  logic [BitW-1:0]  bit_r;

  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;
  logic [WIDTH-1:0] rem_nxt;

  // One restoring step: shift in the next candidate bit, subtract if it fits.
  always_comb begin
    trial = {rem_r, n_r[bit_r]};
    diff  = trial - {1'b0, d_r};
    if (diff[WIDTH]) begin
      rem_nxt = trial[WIDTH-1:0];
    end else begin
      rem_nxt = diff[WIDTH-1:0];
    end
  end

  // Operand registers; the payload needs no reset.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r  <= candidate;
      d_r  <= WIDTH'(2);
      sq_r <= SqW'(4);
    end else if (cmd.next_div) begin
      // (d+1)^2 = d^2 + 2d + 1
      d_r  <= d_r + WIDTH'(1);
      sq_r <= sq_r + {{(SqW - WIDTH - 1){1'b0}}, d_r, 1'b1};
    end
  end

  // Remainder and bit pointer.
  always_ff @(posedge clk) begin
    if (cmd.start_div) begin
      rem_r <= '0;
      bit_r <= BitW'(WIDTH - 1);
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      bit_r <= bit_r - BitW'(1);
    end
  end

  // Status back to the controller.
  always_comb begin
    status.lt_two   = (n_r < WIDTH'(2));
    status.sq_gt_n  = (sq_r > {{WIDTH{1'b0}}, n_r});
    status.rem_zero = (rem_r == '0);
    status.div_last = (bit_r == '0);
  end

endmodule

>>> rtl/tdpt_ctrl.sv
// Controller of the trial-division prime test: the sequencing state machine
// and the output register of the result channel.
// Depends on tdpt_pkg for the command and status structs.
module tdpt_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic                  out_is_prime,
  output tdpt_pkg::ctrl_cmd_t   cmd,
  input  tdpt_pkg::dp_status_t  status
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_TEST  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       verdict_r, verdict_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_bit_r, out_bit_nxt;
  logic       out_free;

  assign in_tready    = (state_r == ST_IDLE);
  assign out_tvalid   = out_valid_r;
  assign out_is_prime = out_bit_r;
  assign out_free     = !out_valid_r || out_tready;

  // Next state, commands and the output register.
  always_comb begin
    state_nxt     = state_r;
    verdict_nxt   = verdict_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_bit_nxt   = out_bit_r;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.lt_two) begin
          verdict_nxt = 1'b0;
          state_nxt   = ST_DONE;
        end else if (status.sq_gt_n) begin
          // No divisor up to the square root divides the candidate.
          verdict_nxt = 1'b1;
          state_nxt   = ST_DONE;
        end else begin
          cmd.start_div = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_TEST;
        end
      end
      ST_TEST: begin
        if (status.rem_zero) begin
          verdict_nxt = 1'b0;
          state_nxt   = ST_DONE;
        end else begin
          cmd.next_div = 1'b1;
          state_nxt    = ST_CHECK;
        end
      end
      ST_DONE: begin
        // Hand the verdict to the output register once it is free.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_bit_nxt   = verdict_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state with synchronous reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    verdict_r <= verdict_nxt;
    out_bit_r <= out_bit_nxt;
  end

endmodule

>>> rtl/trial_division_prime_test.sv
// Trial-division prime test: a candidate request arrives on the in_ stream and
// one verdict request leaves on the out_ stream.
// in_tdata[WIDTH-1:0] carries the candidate; out_tdata[0] is 1 for a prime.
// Latency depends on the candidate. Each tried divisor d passes through one
// square test, WIDTH steps of the bit-serial remainder unit and one zero
// test. Divisors run from 2 while d*d <= candidate, so a prime tries every
// such divisor, a composite stops at its smallest factor, and zero and one
// are answered without any division. For 8-bit values the worst case is
// 14 divisors.
// One candidate is in work at a time; in_tready is high only when the
// sequencer is idle. The verdict sits in an output register, so the next
// candidate is taken and worked on while an earlier verdict waits.
// A stalled out_tready holds the verdict steady; a finished verdict waits
// in the sequencer until the output register frees.
// Reset (rst_n low, synchronous) empties the output register and returns
// the sequencer to idle; no state is kept between candidates.
// Depends on tdpt_pkg, tdpt_ctrl and tdpt_dpath.
module trial_division_prime_test #(
  parameter int WIDTH = tdpt_pkg::WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((WIDTH + 7) / 8) * 8 - 1:0]   in_tdata,   // [WIDTH-1:0] candidate
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [tdpt_pkg::OUT_DATA_W-1:0]      out_tdata   // [0] is_prime
);

  tdpt_pkg::ctrl_cmd_t  cmd;
  tdpt_pkg::dp_status_t status;
  logic                 is_prime;

  // Sequencer and output register.
  tdpt_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_is_prime (is_prime),
    .cmd          (cmd),
    .status       (status)
  );

  // Divisor, square and remainder datapath.
  tdpt_dpath #(
    .WIDTH (WIDTH)
  ) u_dpath (
    .clk       (clk),
    .candidate (in_tdata[WIDTH-1:0]),
    .cmd       (cmd),
    .status    (status)
  );

  assign out_tdata = {{(tdpt_pkg::OUT_DATA_W - 1){1'b0}}, is_prime};

endmodule

>>> rtl/tdpt_chk.sv
// Port-level checker for the trial-division prime test, bound to the top level.
// Depends on trial_division_prime_test and tdpt_pkg.
module tdpt_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [tdpt_pkg::OUT_DATA_W-1:0]  out_tdata
);

  // A stalled verdict stays valid.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("verdict dropped while stalled");

  // A stalled verdict keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("verdict changed while stalled");

  // After taking a candidate the block is busy in the cycle that follows.
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken before the first was worked on");

  // Padding bits of the result bus stay zero.
  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[tdpt_pkg::OUT_DATA_W-1:1] == '0))
    else $error("nonzero padding on the result bus");

  // Reset empties the output and leaves the block ready.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

endmodule

bind trial_division_prime_test tdpt_chk u_tdpt_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
